@@ design/frt_pkg.sv @@
// Shared types and constants of the fragment reassembly tracker.
// No dependencies; imported by frt_pts and fragment_reassembly_tracker.
package frt_pkg;

    // Header kind that marks a point fragment (ASCII 'P').
    localparam logic [7:0] KIND_POINTS = 8'd80;

    // Field widths fixed by the header format.
    localparam int CID_W   = 32;
    localparam int PTS_W   = 24;
    localparam int BYTES_W = 16;
    localparam int PLEN_W  = 16;

    // Result status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_MALFORMED    = 3'd1;
    localparam t_status ST_PARTIAL      = 3'd2;
    localparam t_status ST_TOO_MANY     = 3'd3;
    localparam t_status ST_STALE        = 3'd4;
    localparam t_status ST_NO_SLOT      = 3'd5;
    localparam t_status ST_INCONSISTENT = 3'd6;
    localparam t_status ST_OVERFLOW     = 3'd7;

    // Configuration register indexes (taken from paddr bit 2).
    localparam logic REG_MAX_POINTS  = 1'b0;
    localparam logic REG_MAX_PKT_LEN = 1'b1;

    // One slot entry as kept in the slot memory.
    typedef struct packed {
        logic [PTS_W-1:0] total;
        logic [PTS_W-1:0] received;
    } t_slot_entry;

    // Point count of a fragment and its partial-point flag.
    typedef struct packed {
        logic [BYTES_W-1:0] pts;
        logic               partial;
    } t_pts_res;

endpackage

@@ design/fragment_reassembly_tracker.sv @@
// Fragment reassembly tracker top level: header checks, slot lookup, eviction, completion.
// Depends on frt_pkg, frt_ram (slot totals and counts) and frt_pts (point count).
//
//  Port group         | Direction | Handshake                    | Contents
//  -------------------+-----------+------------------------------+---------------------------
//  Fragment header    | in        | start, busy                  | kind, id, lengths, bytes
//  Result             | out       | o_valid (one-cycle strobe)   | status, slot, evict, done
//  Configuration APB  | in/out    | psel, penable, pwrite, pready| max_points, max_packet_len
//
// A header is taken when start is high and busy is low; busy then stays high until
// the result strobe. Headers rejected by the header checks end after the lookup state,
// inconsistent or overflowing fragments after the read-modify-write, and an accepted
// fragment after the completion search; a full table first adds the lowest-id search.
// Both the eviction search and the completion search walk the slot ids one per cycle.
// Reset clears all slots at once; the slot memory needs no clearing pass.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module fragment_reassembly_tracker #(
    parameter int SLOTS       = 4,
    parameter int POINT_BYTES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Fragment header transaction
    input  logic                    start,
    output logic                    busy,
    input  logic [7:0]              i_kind_byte,
    input  logic [31:0]             i_cloud_id,
    input  logic [15:0]             i_packet_length,
    input  logic [31:0]             i_total_length,
    input  logic [15:0]             i_payload_bytes,
    // Result transaction
    output logic                    o_valid,
    output frt_pkg::t_status        o_status,
    output logic [1:0]              o_slot_used,
    output logic                    o_evict_valid,
    output logic [31:0]             o_evict_cloud,
    output logic [23:0]             o_evict_points,
    output logic                    o_done_valid,
    output logic [31:0]             o_done_cloud,
    output logic [1:0]              o_done_slot,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import frt_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PTS   = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_MIN   = 4'd3;
    localparam logic [3:0] S_EVICT = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_RMW   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // Control state
    logic [3:0]        r_state, n_state;
    logic [CID_W-1:0]  r_cloud [SLOTS];
    logic [CID_W-1:0]  n_cloud [SLOTS];
    logic              r_full  [SLOTS];
    logic              n_full  [SLOTS];
    logic [CID_W-1:0]  r_last, n_last;
    logic              r_valid, n_valid;
    logic [PTS_W-1:0]  r_max_points;
    logic [PLEN_W-1:0] r_max_pkt;

    // Working registers of the transaction
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [CID_W-1:0]  r_cid;
    logic [PTS_W-1:0]  r_total;
    logic              r_bad_hdr;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_fresh, n_fresh;
    logic [CID_W-1:0]  r_min, n_min;
    logic [SLOT_W-1:0] r_old, n_old;
    logic              r_ev, n_ev;
    logic [CID_W-1:0]  r_evc, n_evc;
    logic [PTS_W-1:0]  r_evp, n_evp;
    logic [CID_W-1:0]  r_best, n_best;
    logic              r_dfound, n_dfound;
    logic [SLOT_W-1:0] r_dslot, n_dslot;

    // Result registers
    t_status           r_status, n_status;
    logic [1:0]        r_slot_used, n_slot_used;
    logic              r_evict_valid, n_evict_valid;
    logic [CID_W-1:0]  r_evict_cloud, n_evict_cloud;
    logic [PTS_W-1:0]  r_evict_points, n_evict_points;
    logic              r_done_valid, n_done_valid;
    logic [CID_W-1:0]  r_done_cloud, n_done_cloud;
    logic [1:0]        r_done_slot, n_done_slot;

    // Datapath signals
    logic              accept;
    logic              cfg_wr;
    t_pts_res          pts_res;
    t_slot_entry       ent;
    t_slot_entry       wr_ent;
    logic              ram_we;
    logic              hit, free_found;
    logic [SLOT_W-1:0] hit_idx, free_idx;
    logic [CID_W-1:0]  scan_cloud;
    logic              scan_full;
    logic [PTS_W-1:0]  eff_total;
    logic [PTS_W-1:0]  base_rec;
    logic [PTS_W:0]    sum_rec;
    logic              incons, ovf;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_points <= '1;
            r_max_pkt    <= '1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_POINTS:  r_max_points <= pwdata[PTS_W-1:0];
                REG_MAX_PKT_LEN: r_max_pkt    <= pwdata[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration read-back
    always_comb begin
        unique case (paddr[2])
            REG_MAX_POINTS:  prdata = 32'(r_max_points);
            REG_MAX_PKT_LEN: prdata = 32'(r_max_pkt);
            default:         prdata = '0;
        endcase
    end

    // Point count unit
    frt_pts #(
        .POINT_BYTES (POINT_BYTES)
    ) u_pts (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_bytes (i_payload_bytes),
        .o_res   (pts_res)
    );

    // Slot memory: stated total and received count per slot
    frt_ram #(
        .WIDTH ($bits(t_slot_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_ent),
        .i_raddr (r_slot),
        .o_rdata (ent)
    );

    // Header capture and the malformed check against the limits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cid     <= i_cloud_id;
            r_total   <= i_total_length[PTS_W-1:0];
            r_bad_hdr <= (i_kind_byte != KIND_POINTS) ||
                         (i_total_length > CID_W'(r_max_points)) ||
                         (i_packet_length > r_max_pkt);
        end
    end

    // Parallel id match and free-slot search, lowest index first
    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_cloud[i] == r_cid) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (r_cloud[i] == '0) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Sequential scans look at one slot id per cycle.
    assign scan_cloud = r_cloud[r_idx];
    assign scan_full  = r_full[r_idx];

    // Read-modify-write of the slot entry
    always_comb begin
        eff_total = r_fresh ? r_total : ent.total;
        base_rec  = r_fresh ? '0 : ent.received;
        incons    = !r_fresh && (ent.total != r_total);
        sum_rec   = (PTS_W + 1)'(base_rec) + (PTS_W + 1)'(pts_res.pts);
        ovf       = sum_rec > (PTS_W + 1)'(eff_total);
        wr_ent.total    = eff_total;
        wr_ent.received = ovf ? base_rec : sum_rec[PTS_W-1:0];
        ram_we    = (r_state == S_RMW) && !incons;
    end

    // Sequencer and next-state logic
    always_comb begin
        n_state        = r_state;
        n_cloud        = r_cloud;
        n_full         = r_full;
        n_last         = r_last;
        n_valid        = 1'b0;
        n_idx          = r_idx;
        n_slot         = r_slot;
        n_fresh        = r_fresh;
        n_min          = r_min;
        n_old          = r_old;
        n_ev           = r_ev;
        n_evc          = r_evc;
        n_evp          = r_evp;
        n_best         = r_best;
        n_dfound       = r_dfound;
        n_dslot        = r_dslot;
        n_status       = r_status;
        n_slot_used    = r_slot_used;
        n_evict_valid  = r_evict_valid;
        n_evict_cloud  = r_evict_cloud;
        n_evict_points = r_evict_points;
        n_done_valid   = r_done_valid;
        n_done_cloud   = r_done_cloud;
        n_done_slot    = r_done_slot;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ev    = 1'b0;
                    n_evc   = '0;
                    n_evp   = '0;
                    n_state = S_PTS;
                end
            end

            S_PTS: begin
                n_state = S_LOOK;
            end

            // Early rejects in check order, then pick the slot.
            S_LOOK: begin
                n_slot_used    = '0;
                n_evict_valid  = 1'b0;
                n_evict_cloud  = '0;
                n_evict_points = '0;
                n_done_valid   = 1'b0;
                n_done_cloud   = '0;
                n_done_slot    = '0;
                if (r_bad_hdr) begin
                    n_status = ST_MALFORMED;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (pts_res.partial) begin
                    n_status = ST_PARTIAL;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (PTS_W'(pts_res.pts) > r_max_points) begin
                    n_status = ST_TOO_MANY;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_cid <= r_last) begin
                    n_status = ST_STALE;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (hit) begin
                    n_slot  = hit_idx;
                    n_fresh = 1'b0;
                    n_state = S_RD;
                end else if (free_found) begin
                    n_slot  = free_idx;
                    n_fresh = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_idx   = '0;
                    n_min   = '1;
                    n_old   = '0;
                    n_state = S_MIN;
                end
            end

            // Lowest held id, lowest index on a tie.
            S_MIN: begin
                if (scan_cloud < r_min) begin
                    n_min = scan_cloud;
                    n_old = r_idx;
                end
                if (r_idx == LAST_SLOT) begin
                    n_state = S_EVICT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            // Evict the oldest slot unless the fragment is no newer than it.
            S_EVICT: begin
                if (r_cid <= r_min) begin
                    n_status       = ST_NO_SLOT;
                    n_slot_used    = '0;
                    n_evict_valid  = 1'b0;
                    n_evict_cloud  = '0;
                    n_evict_points = '0;
                    n_done_valid   = 1'b0;
                    n_done_cloud   = '0;
                    n_done_slot    = '0;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_ev    = 1'b1;
                    n_evc   = r_min;
                    n_last  = r_min;
                    n_slot  = r_old;
                    n_fresh = 1'b1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_cloud[i] != '0 && r_cloud[i] <= r_min) begin
                            n_cloud[i] = '0;
                            n_full[i]  = 1'b0;
                        end
                    end
                    n_state = S_RD;
                end
            end

            S_RD: begin
                n_state = S_RMW;
            end

            // Allocate, check consistency and overflow, add the points.
            S_RMW: begin
                if (r_ev) begin
                    n_evp = ent.received;
                end
                if (r_fresh) begin
                    n_cloud[r_slot] = r_cid;
                end
                if (!incons) begin
                    n_full[r_slot] = (wr_ent.received >= eff_total);
                end
                n_evict_valid  = r_ev;
                n_evict_cloud  = r_evc;
                n_evict_points = r_ev ? ent.received : '0;
                n_slot_used    = '0;
                n_done_valid   = 1'b0;
                n_done_cloud   = '0;
                n_done_slot    = '0;
                if (incons) begin
                    n_status = ST_INCONSISTENT;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (ovf) begin
                    n_status = ST_OVERFLOW;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx    = '0;
                    n_best   = r_last;
                    n_dfound = 1'b0;
                    n_dslot  = '0;
                    n_state  = S_DONE;
                end
            end

            // Highest completed id above the last presented one.
            S_DONE: begin
                if (scan_cloud != '0 && scan_cloud > r_best && scan_full) begin
                    n_best   = scan_cloud;
                    n_dslot  = r_idx;
                    n_dfound = 1'b1;
                end
                if (r_idx == LAST_SLOT) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            // Present the completed cloud and free everything at or below it.
            S_FIN: begin
                n_status       = ST_OK;
                n_slot_used    = 2'(r_slot);
                n_evict_valid  = r_ev;
                n_evict_cloud  = r_evc;
                n_evict_points = r_evp;
                n_done_valid   = r_dfound;
                n_done_cloud   = r_dfound ? r_best : '0;
                n_done_slot    = r_dfound ? 2'(r_dslot) : '0;
                if (r_dfound) begin
                    n_last = r_best;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_cloud[i] != '0 && r_cloud[i] <= r_best) begin
                            n_cloud[i] = '0;
                            n_full[i]  = 1'b0;
                        end
                    end
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_cloud[i] <= '0;
                r_full[i]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_valid <= n_valid;
            r_cloud <= n_cloud;
            r_full  <= n_full;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_slot         <= n_slot;
        r_fresh        <= n_fresh;
        r_min          <= n_min;
        r_old          <= n_old;
        r_ev           <= n_ev;
        r_evc          <= n_evc;
        r_evp          <= n_evp;
        r_best         <= n_best;
        r_dfound       <= n_dfound;
        r_dslot        <= n_dslot;
        r_status       <= n_status;
        r_slot_used    <= n_slot_used;
        r_evict_valid  <= n_evict_valid;
        r_evict_cloud  <= n_evict_cloud;
        r_evict_points <= n_evict_points;
        r_done_valid   <= n_done_valid;
        r_done_cloud   <= n_done_cloud;
        r_done_slot    <= n_done_slot;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_slot_used    = r_slot_used;
    assign o_evict_valid  = r_evict_valid;
    assign o_evict_cloud  = r_evict_cloud;
    assign o_evict_points = r_evict_points;
    assign o_done_valid   = r_done_valid;
    assign o_done_cloud   = r_done_cloud;
    assign o_done_slot    = r_done_slot;

endmodule

@@ design/frt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the slot memory of the tracker.
module frt_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/frt_pts.sv @@
// Point count unit: payload bytes divided by the point size, with remainder check.
// Depends on frt_pkg; two register stages (reciprocal product, then corrected quotient).
module frt_pts #(
    parameter int POINT_BYTES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [15:0]            i_bytes,
    output frt_pkg::t_pts_res      o_res
);
    import frt_pkg::*;

    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = BYTES_W + RECIP_W;
    localparam int PB_W        = $clog2(POINT_BYTES + 1);
    localparam int REM_W       = PB_W + 1;
    localparam int QPB_W       = BYTES_W + PB_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / POINT_BYTES);
    localparam logic [PB_W-1:0]    PB    = PB_W'(POINT_BYTES);

    logic [BYTES_W-1:0] r_bytes;
    logic [PROD_W-1:0]  r_prod;
    t_pts_res           r_res;
    t_pts_res           n_res;
    logic [BYTES_W-1:0] q0;
    logic [QPB_W-1:0]   q0_pb;
    logic [QPB_W-1:0]   diff;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   rem_fix;

    // Stage one: quotient estimate by reciprocal multiplication.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_prod  <= PROD_W'(i_bytes) * PROD_W'(RECIP);
        end
    end

    // Stage two: the estimate is low by at most one; one compare and subtract fixes it.
    always_comb begin
        q0      = r_prod[RECIP_SHIFT +: BYTES_W];
        q0_pb   = QPB_W'(q0) * QPB_W'(PB);
        diff    = QPB_W'(r_bytes) - q0_pb;
        rem     = diff[REM_W-1:0];
        rem_fix = rem;
        n_res.pts = q0;
        if (rem >= REM_W'(PB)) begin
            rem_fix   = rem - REM_W'(PB);
            n_res.pts = q0 + BYTES_W'(1);
        end
        n_res.partial = (rem_fix != '0);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

@@ tb/fragment_reassembly_tracker_test.sv @@
// Self-checking testbench for the fragment reassembly tracker: directed and random headers.
// Depends on frt_pkg and fragment_reassembly_tracker; predicts every result internally.
module fragment_reassembly_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import frt_pkg::*;

    localparam int SLOT_COUNT = 4;
    localparam int PT_BYTES   = 16;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_MAX_POINTS  = {REG_MAX_POINTS, 2'b00};
    localparam logic [2:0] ADDR_MAX_PKT_LEN = {REG_MAX_PKT_LEN, 2'b00};

    // One fragment header as driven on the input ports.
    typedef struct packed {
        logic [7:0]  kind;
        logic [31:0] cid;
        logic [15:0] plen;
        logic [31:0] total;
        logic [15:0] bytes;
    } t_frag;

    // One result transaction as it should appear on the output ports.
    typedef struct packed {
        t_status     status;
        logic [1:0]  slot;
        logic        evict_valid;
        logic [31:0] evict_cloud;
        logic [23:0] evict_points;
        logic        done_valid;
        logic [31:0] done_cloud;
        logic [1:0]  done_slot;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_kind_byte = '0;
    logic [31:0] i_cloud_id = '0;
    logic [15:0] i_packet_length = '0;
    logic [31:0] i_total_length = '0;
    logic [15:0] i_payload_bytes = '0;
    logic        o_valid;
    t_status     o_status;
    logic [1:0]  o_slot_used;
    logic        o_evict_valid;
    logic [31:0] o_evict_cloud;
    logic [23:0] o_evict_points;
    logic        o_done_valid;
    logic [31:0] o_done_cloud;
    logic [1:0]  o_done_slot;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fragment_reassembly_tracker #(
        .SLOTS       (SLOT_COUNT),
        .POINT_BYTES (PT_BYTES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind_byte     (i_kind_byte),
        .i_cloud_id      (i_cloud_id),
        .i_packet_length (i_packet_length),
        .i_total_length  (i_total_length),
        .i_payload_bytes (i_payload_bytes),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot_used     (o_slot_used),
        .o_evict_valid   (o_evict_valid),
        .o_evict_cloud   (o_evict_cloud),
        .o_evict_points  (o_evict_points),
        .o_done_valid    (o_done_valid),
        .o_done_cloud    (o_done_cloud),
        .o_done_slot     (o_done_slot),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the slot table and limits.
    logic [31:0] tab_cloud [SLOT_COUNT] = '{default: '0};
    logic [23:0] tab_total [SLOT_COUNT] = '{default: '0};
    logic [23:0] tab_rcvd  [SLOT_COUNT] = '{default: '0};
    logic [31:0] last_shown = '0;
    logic [23:0] lim_points = 24'hFF_FFFF;
    logic [15:0] lim_pkt_len = 16'hFFFF;

    t_frag       frag_pending [$];
    t_verdict    pending_verdicts [$];
    t_frag       drv_frag = '0;
    int unsigned sent_cnt = 0;
    int unsigned taken_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        drain_hold = 1'b0;
    int unsigned id_base = 1000;
    int          err_cnt = 0;

    // Free every slot whose cloud id has already been presented.
    function automatic void clear_shown();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tab_cloud[i] != 0 && tab_cloud[i] <= last_shown) begin
                tab_cloud[i] = '0;
                tab_total[i] = '0;
                tab_rcvd[i]  = '0;
            end
        end
    endfunction

    // Apply one header to the shadow table and return the result it must produce.
    function automatic t_verdict track_fragment(input t_frag f);
        t_verdict    r;
        logic [15:0] pts;
        int          slot;
        int          done;
        int          oldest;
        logic [31:0] done_id;
        r = '0;
        if (f.kind != KIND_POINTS || f.total > {8'h00, lim_points} || f.plen > lim_pkt_len) begin
            r.status = ST_MALFORMED;
            return r;
        end
        if (f.bytes % PT_BYTES != 0) begin
            r.status = ST_PARTIAL;
            return r;
        end
        pts = f.bytes / PT_BYTES;
        if ({8'h00, pts} > lim_points) begin
            r.status = ST_TOO_MANY;
            return r;
        end
        if (f.cid <= last_shown) begin
            r.status = ST_STALE;
            return r;
        end

        // Slot lookup: matching id first, then the first free slot.
        slot = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && tab_cloud[i] == f.cid) slot = i;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && tab_cloud[i] == 0) slot = i;

        // Table full: the lowest id is evicted unless the fragment is not newer.
        if (slot < 0) begin
            oldest = 0;
            for (int i = 1; i < SLOT_COUNT; i++)
                if (tab_cloud[i] < tab_cloud[oldest]) oldest = i;
            if (f.cid <= tab_cloud[oldest]) begin
                r.status = ST_NO_SLOT;
                return r;
            end
            r.evict_valid  = 1'b1;
            r.evict_cloud  = tab_cloud[oldest];
            r.evict_points = tab_rcvd[oldest];
            last_shown     = tab_cloud[oldest];
            clear_shown();
            slot = oldest;
        end

        if (tab_cloud[slot] == 0) begin
            tab_cloud[slot] = f.cid;
            tab_total[slot] = f.total[23:0];
            tab_rcvd[slot]  = '0;
        end
        if ({8'h00, tab_total[slot]} != f.total) begin
            r.status = ST_INCONSISTENT;
            return r;
        end
        if (32'(tab_rcvd[slot]) + 32'(pts) > 32'(tab_total[slot])) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        tab_rcvd[slot] = tab_rcvd[slot] + 24'(pts);
        r.status = ST_OK;
        r.slot   = 2'(slot);

        // Present the highest completed cloud above the last presented one.
        done    = -1;
        done_id = last_shown;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tab_cloud[i] != 0 && tab_cloud[i] > done_id && tab_rcvd[i] >= tab_total[i]) begin
                done_id = tab_cloud[i];
                done    = i;
            end
        end
        if (done >= 0) begin
            last_shown      = done_id;
            tab_cloud[done] = '0;
            tab_total[done] = '0;
            tab_rcvd[done]  = '0;
            clear_shown();
            r.done_valid = 1'b1;
            r.done_cloud = done_id;
            r.done_slot  = 2'(done);
        end
        return r;
    endfunction

    task automatic queue_frag(input logic [7:0] kind, input logic [31:0] cid,
                              input logic [15:0] plen, input logic [31:0] total,
                              input logic [15:0] bytes);
        frag_pending.push_back({kind, cid, plen, total, bytes});
    endtask

    // Mostly well-formed fragments of a sliding window of clouds, with some
    // broken headers and pure noise mixed in.
    task automatic queue_random(input int count, input int unsigned span,
                                input int unsigned plen_lim);
        t_frag       f;
        int unsigned pick;
        int unsigned pts;
        for (int n = 0; n < count; n++) begin
            pick    = $urandom_range(0, 99);
            pts     = $urandom_range(0, 3);
            f.kind  = KIND_POINTS;
            f.cid   = id_base + $urandom_range(0, 3);
            f.total = f.cid % (span + 1);
            f.plen  = 16'($urandom_range(0, plen_lim));
            f.bytes = 16'(pts * PT_BYTES);
            if (pick < 8) begin
                f.kind  = 8'($urandom);
                f.cid   = $urandom;
                f.plen  = 16'($urandom);
                f.total = $urandom;
                f.bytes = 16'($urandom);
                if (f.kind == KIND_POINTS) f.kind = ~KIND_POINTS;
            end else if (pick < 10) begin
                f.bytes = 16'(pts * PT_BYTES + $urandom_range(1, PT_BYTES - 1));
            end else if (pick < 12) begin
                f.total = f.total + $urandom_range(1, 3);
            end else if (pick < 14) begin
                f.cid = id_base - $urandom_range(4, 40);
            end else if (pick < 16) begin
                f.bytes = 16'($urandom_range(4, 4095) * PT_BYTES);
            end else if (pick < 17 && plen_lim < 16'hFFFF) begin
                f.plen = 16'($urandom_range(plen_lim + 1, 16'hFFFF));
            end
            frag_pending.push_back(f);
            if ($urandom_range(0, 2) == 0) id_base += $urandom_range(1, 2);
        end
    endtask

    // Wait until every queued header has been taken and every result has arrived.
    task automatic settle();
        while (frag_pending.size() != 0 || sent_cnt != taken_cnt ||
               pending_verdicts.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] seen;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_MAX_POINTS) lim_points = data[23:0];
        else lim_pkt_len = data[15:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        seen = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== data) begin
            $error("prdata: expected %0h, got %0h", data, seen);
            err_cnt++;
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Header driver: bursts of transactions separated by random gaps, and now
    // and then a hold until the block has drained.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (sent_cnt == taken_cnt) begin
                if (drain_hold) begin
                    if (pending_verdicts.size() == 0 && !busy) drain_hold = 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (frag_pending.size() > 0) begin
                    drv_frag = frag_pending.pop_front();
                    sent_cnt++;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        drain_hold = ($urandom_range(0, 30) == 0);
                    end
                end
            end
            start           <= (sent_cnt != taken_cnt);
            i_kind_byte     <= drv_frag.kind;
            i_cloud_id      <= drv_frag.cid;
            i_packet_length <= drv_frag.plen;
            i_total_length  <= drv_frag.total;
            i_payload_bytes <= drv_frag.bytes;
        end
    end

    // Result monitor and header capture. The result is checked before a header
    // taken on the same edge is predicted, since it belongs to an older one.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result transaction with no header outstanding");
                    err_cnt++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        err_cnt++;
                    end
                    if (o_slot_used !== want.slot) begin
                        $error("slot_used: expected %0d, got %0d", want.slot, o_slot_used);
                        err_cnt++;
                    end
                    if (o_evict_valid !== want.evict_valid) begin
                        $error("evict_valid: expected %0d, got %0d",
                               want.evict_valid, o_evict_valid);
                        err_cnt++;
                    end
                    if (o_evict_cloud !== want.evict_cloud) begin
                        $error("evict_cloud: expected %0h, got %0h",
                               want.evict_cloud, o_evict_cloud);
                        err_cnt++;
                    end
                    if (o_evict_points !== want.evict_points) begin
                        $error("evict_points: expected %0d, got %0d",
                               want.evict_points, o_evict_points);
                        err_cnt++;
                    end
                    if (o_done_valid !== want.done_valid) begin
                        $error("done_valid: expected %0d, got %0d",
                               want.done_valid, o_done_valid);
                        err_cnt++;
                    end
                    if (o_done_cloud !== want.done_cloud) begin
                        $error("done_cloud: expected %0h, got %0h",
                               want.done_cloud, o_done_cloud);
                        err_cnt++;
                    end
                    if (o_done_slot !== want.done_slot) begin
                        $error("done_slot: expected %0d, got %0d", want.done_slot, o_done_slot);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                pending_verdicts.push_back(track_fragment({i_kind_byte, i_cloud_id,
                    i_packet_length, i_total_length, i_payload_bytes}));
                taken_cnt++;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("fragment_reassembly_tracker verification failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Header checks, stale ids, inconsistent totals, overflow and completion.
        queue_frag(8'h00, 32'd1, 16'd0, 32'd1, 16'd16);
        queue_frag(KIND_POINTS, 32'd1, 16'd0, 32'h0100_0000, 16'd16);
        queue_frag(KIND_POINTS, 32'd1, 16'd0, 32'd1, 16'hFFFF);
        queue_frag(KIND_POINTS, 32'd0, 16'd0, 32'd1, 16'd16);
        queue_frag(KIND_POINTS, 32'd10, 16'hFFFF, 32'd5000, 16'hFFF0);
        queue_frag(KIND_POINTS, 32'd10, 16'd0, 32'd4000, 16'd16);
        queue_frag(KIND_POINTS, 32'd10, 16'd0, 32'd5000, 16'hFFF0);
        queue_frag(KIND_POINTS, 32'd10, 16'd0, 32'd5000, 16'(905 * PT_BYTES));
        queue_frag(KIND_POINTS, 32'd5, 16'd0, 32'd1, 16'd16);
        // Fill the table, then a too-old id, then an eviction that also completes.
        queue_frag(KIND_POINTS, 32'd20, 16'd0, 32'd3, 16'd16);
        queue_frag(KIND_POINTS, 32'd30, 16'd0, 32'd3, 16'd16);
        queue_frag(KIND_POINTS, 32'd25, 16'd0, 32'd3, 16'd16);
        queue_frag(KIND_POINTS, 32'd40, 16'd0, 32'd3, 16'd16);
        queue_frag(KIND_POINTS, 32'd15, 16'd0, 32'd3, 16'd16);
        queue_frag(KIND_POINTS, 32'd50, 16'd0, 32'd2, 16'd32);
        // Eviction that stands although the fragment then overflows its new slot.
        queue_frag(KIND_POINTS, 32'd60, 16'd0, 32'd5, 16'd16);
        queue_frag(KIND_POINTS, 32'd70, 16'd0, 32'd5, 16'd16);
        queue_frag(KIND_POINTS, 32'd80, 16'd0, 32'd5, 16'd16);
        queue_frag(KIND_POINTS, 32'd90, 16'd0, 32'd5, 16'd16);
        queue_frag(KIND_POINTS, 32'd100, 16'd0, 32'd1, 16'd32);
        settle();

        // Tight limits: point count and packet length checks.
        write_reg(ADDR_MAX_POINTS, 32'd2);
        write_reg(ADDR_MAX_PKT_LEN, 32'd100);
        queue_frag(KIND_POINTS, 32'd200, 16'd50, 32'd2, 16'd48);
        queue_frag(KIND_POINTS, 32'd200, 16'd101, 32'd2, 16'd32);
        queue_frag(KIND_POINTS, 32'd200, 16'd100, 32'd3, 16'd32);
        queue_frag(KIND_POINTS, 32'd200, 16'd100, 32'd2, 16'd32);
        settle();

        // Random phases over several limit settings, extremes included.
        write_reg(ADDR_MAX_POINTS, 32'hFF_FFFF);
        write_reg(ADDR_MAX_PKT_LEN, 32'hFFFF);
        queue_random(500, 6, 16'hFFFF);
        settle();

        write_reg(ADDR_MAX_POINTS, 32'd0);
        write_reg(ADDR_MAX_PKT_LEN, 32'd0);
        queue_random(60, 3, 0);
        settle();

        write_reg(ADDR_MAX_POINTS, $urandom_range(8, 40));
        write_reg(ADDR_MAX_PKT_LEN, $urandom_range(200, 16'hFFFE));
        queue_random(420, 10, lim_pkt_len);
        settle();

        write_reg(ADDR_MAX_POINTS, 32'hFF_FFFF);
        write_reg(ADDR_MAX_PKT_LEN, $urandom_range(0, 199));
        queue_random(380, 6, lim_pkt_len);
        settle();

        write_reg(ADDR_MAX_POINTS, $urandom_range(1, 5));
        write_reg(ADDR_MAX_PKT_LEN, 32'hFFFF);
        queue_random(240, 6, 16'hFFFF);
        settle();

        // Top of the id range: largest total, largest id completes, then is stale.
        write_reg(ADDR_MAX_POINTS, 32'hFF_FFFF);
        queue_frag(KIND_POINTS, 32'hFFFF_FFFE, 16'hFFFF, 32'h00FF_FFFF, 16'hFFF0);
        queue_frag(KIND_POINTS, 32'hFFFF_FFFF, 16'd0, 32'd1, 16'd16);
        queue_frag(KIND_POINTS, 32'hFFFF_FFFF, 16'd0, 32'd1, 16'd16);
        settle();

        // Let any stray result transaction show up before the verdict.
        repeat (30) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("fragment_reassembly_tracker verification clean");
        end else begin
            $display("fragment_reassembly_tracker verification failed");
        end
        $finish;
    end

endmodule
